@@ rtl/core/vmac_pkg.sv @@
// Package with shared constants, codes and types of the memory access checker.
`default_nettype none
package vmac_pkg;

  localparam int unsigned TableEntries = 64;
  localparam int unsigned IdxW         = $clog2(TableEntries);
  localparam int unsigned CntW         = $clog2(TableEntries + 1);

  localparam logic [2:0] CmdRecManaged = 3'd0;
  localparam logic [2:0] CmdRecNative  = 3'd1;
  localparam logic [2:0] CmdFree       = 3'd2;
  localparam logic [2:0] CmdStkAlloc   = 3'd3;
  localparam logic [2:0] CmdStkRestore = 3'd4;
  localparam logic [2:0] CmdValidate   = 3'd5;

  localparam logic [3:0] StOk       = 4'd0;
  localparam logic [3:0] StNull     = 4'd1;
  localparam logic [3:0] StInvalid  = 4'd2;
  localparam logic [3:0] StFreed    = 4'd3;
  localparam logic [3:0] StNotBlock = 4'd4;
  localparam logic [3:0] StManaged  = 4'd5;
  localparam logic [3:0] StDouble   = 4'd6;
  localparam logic [3:0] StOverflow = 4'd7;
  localparam logic [3:0] StOom      = 4'd8;
  localparam logic [3:0] StFull     = 4'd9;

  localparam int unsigned FlagValid  = 0;
  localparam int unsigned FlagNative = 1;
  localparam int unsigned FlagFreed  = 2;

  localparam logic CfgStackBase = 1'b0;
  localparam logic CfgStackSize = 1'b1;

  typedef struct packed {
    logic            load;
    logic            calc1;
    logic            calc2;
    logic            scan_rd;
    logic [IdxW-1:0] scan_idx;
    logic            fin1;
    logic            fin2;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ rtl/core/vmac_ram.sv @@
// Generic single-port RAM with registered read data.
`default_nettype none
module vmac_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

@@ rtl/core/vmac_ctrl.sv @@
// Controller state machine that sequences one request through the datapath.
`default_nettype none
module vmac_ctrl
  import vmac_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output      logic     in_ready_o,
  output      dp_cmd_t  cmd_o,
  input  wire dp_stat_t stat_i
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CALC1 = 7'b0000010,
    S_CALC2 = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_DRAIN = 7'b0010000,
    S_FIN1  = 7'b0100000,
    S_FIN2  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.scan_idx = cnt_q[IdxW-1:0];
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_CALC1;
        end
      end
      S_CALC1: begin
        cmd_o.calc1 = 1'b1;
        state_d = S_CALC2;
      end
      S_CALC2: begin
        cmd_o.calc2 = 1'b1;
        cnt_d = '0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(TableEntries - 1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: state_d = S_FIN1;
      S_FIN1: begin
        cmd_o.fin1 = 1'b1;
        state_d = S_FIN2;
      end
      S_FIN2: begin
        if (!stat_i.out_busy) begin
          cmd_o.fin2 = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/vmac_dp.sv @@
// Datapath: configuration, stack pointer, block table and result register.
`default_nettype none
module vmac_dp
  import vmac_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire dp_cmd_t     cmd_i,
  output      dp_stat_t    stat_o,
  input  wire logic [2:0]  in_command_i,
  input  wire logic [63:0] in_address_i,
  input  wire logic [63:0] in_size_i,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [3:0]  out_status_o,
  output      logic [63:0] out_result_address_o
);
  logic [63:0] base_q, top_q;
  logic [31:0] ssize_q;
  logic [2:0]  command_q;
  logic [63:0] addr_q, size_q;
  logic [64:0] off_q, next_q, estk_q;
  logic        end_c_q;
  logic [63:0] aoff_q, res_q, rel_q;
  logic        in_stack_q;
  logic [2:0]  flags_q [TableEntries];

  logic            cmp_v_q;
  logic [IdxW-1:0] cmp_idx_q;
  logic            match_q, free_q, best_q;
  logic [IdxW-1:0] match_idx_q, free_idx_q;
  logic [2:0]      match_flags_q;
  logic            best_freed_q;
  logic [63:0]     best_start_q, best_size_q;

  logic            ram_we;
  logic [IdxW-1:0] ram_addr;
  logic [127:0]    ram_rdata;
  logic [63:0]     ent_start, ent_size;
  logic [2:0]      ent_flags;
  logic            ent_valid;
  logic [2:0]      pad;
  logic [2:0]      sp_low;
  logic [64:0]     rel_end;
  logic [3:0]      status;
  logic [63:0]     res_addr;
  logic            top_we;
  logic [63:0]     top_new;
  logic            flag_we;
  logic [IdxW-1:0] flag_idx;
  logic [2:0]      flag_new;
  logic [IdxW-1:0] rec_idx;

  assign ent_start = ram_rdata[63:0];
  assign ent_size  = ram_rdata[127:64];
  assign ent_flags = flags_q[cmp_idx_q];
  assign ent_valid = ent_flags[FlagValid];
  assign sp_low    = base_q[2:0] + top_q[2:0];
  assign pad       = 3'd0 - sp_low;
  assign rel_end   = {1'b0, rel_q} + {1'b0, size_q};
  assign rec_idx   = match_q ? match_idx_q : free_idx_q;
  assign stat_o.out_busy = out_valid_o && !out_ready_i;

  vmac_ram #(.Width(128), .Depth(TableEntries)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i ({size_q, addr_q}),
    .rdata_o (ram_rdata)
  );

  // Final decision for the request; all sums but the end offset within the best block are prepared in earlier steps.
  always_comb begin
    status   = StInvalid;
    res_addr = '0;
    ram_we   = 1'b0;
    ram_addr = cmd_i.fin2 ? rec_idx : cmd_i.scan_idx;
    top_we   = 1'b0;
    top_new  = next_q[63:0];
    flag_we  = 1'b0;
    flag_idx = rec_idx;
    flag_new = '0;
    case (command_q)
      CmdRecManaged, CmdRecNative: begin
        if (addr_q == '0) begin
          status = StOom;
        end else if (match_q || free_q) begin
          status   = StOk;
          res_addr = addr_q;
          ram_we   = cmd_i.fin2;
          flag_we  = cmd_i.fin2;
          flag_new[FlagValid]  = 1'b1;
          flag_new[FlagNative] = (command_q == CmdRecNative);
        end else begin
          status = StFull;
        end
      end
      CmdFree: begin
        flag_idx = match_idx_q;
        flag_new = match_flags_q;
        flag_new[FlagFreed] = 1'b1;
        if (addr_q == '0) begin
          status = StOk;
        end else if (!match_q) begin
          status = StNotBlock;
        end else if (!match_flags_q[FlagNative]) begin
          status = StManaged;
        end else if (match_flags_q[FlagFreed]) begin
          status = StDouble;
        end else begin
          status  = StOk;
          flag_we = cmd_i.fin2;
        end
      end
      CmdStkAlloc: begin
        if (off_q[64] || next_q[64] || next_q[63:0] > {32'd0, ssize_q}) begin
          status = StOverflow;
        end else begin
          status   = StOk;
          res_addr = res_q;
          top_we   = cmd_i.fin2;
        end
      end
      CmdStkRestore: begin
        status  = StOk;
        top_new = aoff_q;
        top_we  = cmd_i.fin2;
      end
      CmdValidate: begin
        if (size_q == '0) begin
          status = StOk;
        end else if (addr_q == '0) begin
          status = StNull;
        end else if (end_c_q) begin
          status = StInvalid;
        end else if (in_stack_q) begin
          status = (estk_q[64] || estk_q[63:0] > top_q) ? StInvalid : StOk;
        end else if (!best_q || rel_q >= best_size_q) begin
          status = StOk;
        end else if (best_freed_q) begin
          status = StFreed;
        end else if (rel_end[64] || rel_end[63:0] > best_size_q) begin
          status = StInvalid;
        end else begin
          status = StOk;
        end
      end
      default: status = StInvalid;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      ssize_q     <= '0;
      top_q       <= '0;
      out_valid_o <= 1'b0;
      cmp_v_q     <= 1'b0;
      for (int i = 0; i < TableEntries; i++) begin
        flags_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CfgStackBase) begin
          base_q <= cfg_data_i;
        end else begin
          ssize_q <= cfg_data_i[31:0];
        end
      end
      if (top_we) begin
        top_q <= top_new;
      end
      if (flag_we) begin
        flags_q[flag_idx] <= flag_new;
      end
      cmp_v_q <= cmd_i.scan_rd;
      if (cmd_i.fin2) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmd_i.scan_idx;
    if (cmd_i.load) begin
      command_q <= in_command_i;
      addr_q    <= in_address_i;
      size_q    <= in_size_i;
      match_q   <= 1'b0;
      free_q    <= 1'b0;
      best_q    <= 1'b0;
    end
    if (cmd_i.calc1) begin
      off_q   <= {1'b0, top_q} + {62'd0, pad};
      aoff_q  <= addr_q - base_q;
      end_c_q <= (addr_q + size_q) < addr_q;
    end
    if (cmd_i.calc2) begin
      next_q     <= {1'b0, off_q[63:0]} + {1'b0, size_q};
      res_q      <= base_q + off_q[63:0];
      estk_q     <= {1'b0, aoff_q} + {1'b0, size_q};
      in_stack_q <= aoff_q < {32'd0, ssize_q};
    end
    // One table entry is compared per cycle, in the cycle after its read.
    if (cmp_v_q) begin
      if (ent_valid && ent_start == addr_q && !match_q) begin
        match_q       <= 1'b1;
        match_idx_q   <= cmp_idx_q;
        match_flags_q <= ent_flags;
      end
      if (!ent_valid && !free_q) begin
        free_q     <= 1'b1;
        free_idx_q <= cmp_idx_q;
      end
      if (ent_valid && ent_start <= addr_q && (!best_q || ent_start > best_start_q)) begin
        best_q       <= 1'b1;
        best_freed_q <= ent_flags[FlagFreed];
        best_start_q <= ent_start;
        best_size_q  <= ent_size;
      end
    end
    if (cmd_i.fin1) begin
      rel_q <= addr_q - best_start_q;
    end
    if (cmd_i.fin2) begin
      out_status_o         <= status;
      out_result_address_o <= res_addr;
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/vm_memory_access_checker.sv @@
// Top level of the memory access checker for a virtual machine.
//
// Requests enter on the s_axis channel: tdata holds command, address and
// size. Each request yields exactly one response on m_axis: tdata holds
// status and result address. Configuration registers (0 stack base,
// 1 stack size) are written through the cfg channel, which is always ready
// and should be used only while no request is in flight.
// The response is loaded into the output register once its request has passed
// S_CALC1, S_CALC2, a scan of the whole block table, S_DRAIN, S_FIN1 and
// S_FIN2: the block table sits in a single-port RAM and every request scans
// it one entry per cycle. A new request is taken in the cycle after the
// previous response has been loaded into the output register, so a request
// is never accepted while another one is still in progress.
// Reset clears the stack pointer, the configuration and all table valid
// flags. When the receiver stalls, the response waits in the output
// register, and a later request finishes its scan but holds its response
// until the register is free.
`default_nettype none
module vm_memory_access_checker
  import vmac_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output      logic         s_axis_tready,
  input  wire logic [135:0] s_axis_tdata,  // command[2:0], address[66:3], size[130:67]
  output      logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output      logic [71:0]  m_axis_tdata,  // status[3:0], result_address[67:4]
  input  wire logic         cfg_valid_i,
  output      logic         cfg_ready_o,
  input  wire logic         cfg_index_i,
  input  wire logic [63:0]  cfg_data_i
);
  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [3:0]  status;
  logic [63:0] result_address;

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = {4'd0, result_address, status};

  vmac_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  vmac_dp u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .stat_o               (stat),
    .in_command_i         (s_axis_tdata[2:0]),
    .in_address_i         (s_axis_tdata[66:3]),
    .in_size_i            (s_axis_tdata[130:67]),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .out_valid_o          (m_axis_tvalid),
    .out_ready_i          (m_axis_tready),
    .out_status_o         (status),
    .out_result_address_o (result_address)
  );
endmodule
`default_nettype wire

@@ verif/tb_vm_memory_access_checker.sv @@
// Self-checking testbench for the VM memory access checker: block table, stack and validation.
`timescale 1ns / 1ps
module tb_vm_memory_access_checker
  import vmac_pkg::*;
();

  localparam int unsigned Slots = TableEntries;
  localparam int unsigned StallLimit = 20000;

  // Fields from the highest bit down, as on s_axis_tdata.
  typedef struct packed {
    logic [63:0] len;
    logic [63:0] addr;
    logic [2:0]  cmd;
  } request_t;

  // Fields from the highest bit down, as on m_axis_tdata.
  typedef struct packed {
    logic [63:0] res_addr;
    logic [3:0]  status;
  } response_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = 1'b0;
  logic [63:0] cfg_data_i = '0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  vm_memory_access_checker u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // Predictor state.
  logic [63:0] stk_base, stk_len, stk_off;
  logic [63:0] blk_start [Slots];
  logic [63:0] blk_len [Slots];
  logic        blk_valid [Slots];
  logic        blk_native [Slots];
  logic        blk_freed [Slots];

  request_t  pending_reqs[$];
  response_t expected_resps[$];
  int errors = 0;
  bit in_taken = 1'b0;
  int watchdog = 0;
  int unsigned gap_left = 0, burst_left = 0;

  function automatic int lookup_slot(logic [63:0] a);
    for (int i = 0; i < Slots; i++)
      if (blk_valid[i] && blk_start[i] == a) return i;
    return -1;
  endfunction

  function automatic response_t predict_access(request_t r);
    response_t o;
    int i, best;
    logic [63:0] pad, off, nxt, aoff, rel, e;
    o = '{64'd0, StOk};
    case (r.cmd)
      CmdRecManaged, CmdRecNative: begin
        if (r.addr == 0) o.status = StOom;
        else begin
          i = lookup_slot(r.addr);
          if (i < 0)
            for (int k = Slots - 1; k >= 0; k--) if (!blk_valid[k]) i = k;
          if (i < 0) o.status = StFull;
          else begin
            blk_start[i] = r.addr;
            blk_len[i] = r.len;
            blk_valid[i] = 1'b1;
            blk_native[i] = (r.cmd == CmdRecNative);
            blk_freed[i] = 1'b0;
            o.res_addr = r.addr;
          end
        end
      end
      CmdFree: begin
        if (r.addr != 0) begin
          i = lookup_slot(r.addr);
          if (i < 0) o.status = StNotBlock;
          else if (!blk_native[i]) o.status = StManaged;
          else if (blk_freed[i]) o.status = StDouble;
          else blk_freed[i] = 1'b1;
        end
      end
      CmdStkAlloc: begin
        pad = (64'd8 - ((stk_base + stk_off) & 64'd7)) & 64'd7;
        off = stk_off + pad;
        nxt = off + r.len;
        if (off < stk_off || nxt < off || nxt > stk_len) o.status = StOverflow;
        else begin
          stk_off = nxt;
          o.res_addr = stk_base + off;
        end
      end
      CmdStkRestore: stk_off = r.addr - stk_base;
      CmdValidate: begin
        aoff = r.addr - stk_base;
        if (r.len == 0) o.status = StOk;
        else if (r.addr == 0) o.status = StNull;
        else if (r.addr + r.len < r.addr) o.status = StInvalid;
        else if (aoff < stk_len) begin
          e = aoff + r.len;
          if (e < aoff || e > stk_off) o.status = StInvalid;
        end else begin
          best = -1;
          for (int k = 0; k < Slots; k++)
            if (blk_valid[k] && blk_start[k] <= r.addr &&
                (best < 0 || blk_start[k] > blk_start[best])) best = k;
          if (best >= 0) begin
            rel = r.addr - blk_start[best];
            e = rel + r.len;
            if (rel >= blk_len[best]) o.status = StOk;
            else if (blk_freed[best]) o.status = StFreed;
            else if (e < rel || e > blk_len[best]) o.status = StInvalid;
          end
        end
      end
      default: o.status = StInvalid;
    endcase
    return o;
  endfunction

  // Driver: bursts with random gaps.
  always @(negedge clk_i) begin
    bit taken;
    taken = in_taken;
    in_taken = 1'b0;
    if (rst_ni) begin
      if (taken) begin
        void'(pending_reqs.pop_front());
        if (burst_left > 0) burst_left--;
        if (burst_left == 0)
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
      end
      // A request that is still waiting stays on the bus unchanged.
      if (!s_axis_tvalid || taken) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          if (burst_left == 0) burst_left = $urandom_range(1, 12);
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {5'd0, pending_reqs[0]};
        end else s_axis_tvalid <= 1'b0;
      end
      m_axis_tready <= ($urandom_range(0, 7) < 5) || ($time / 40000) % 4 == 0;
    end
  end

  // Monitor: predict on request, check on response.
  always @(posedge clk_i) begin
    response_t got, want;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        watchdog <= 0;
      else
        watchdog <= watchdog + 1;
      if (s_axis_tvalid && s_axis_tready) begin
        in_taken = 1'b1;
        expected_resps.push_back(predict_access(request_t'(s_axis_tdata[130:0])));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = response_t'(m_axis_tdata[67:0]);
        if (expected_resps.size() == 0) begin
          $display("%0t: response with none expected, actual %h", $time, got);
          errors++;
        end else begin
          want = expected_resps.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
          end
          if (got.res_addr !== want.res_addr) begin
            $display("%0t: address expected %h actual %h", $time, want.res_addr, got.res_addr);
            errors++;
          end
        end
      end
      if (watchdog > StallLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic drain_all();
    while (pending_reqs.size() > 0 || expected_resps.size() > 0) @(posedge clk_i);
    repeat (2 * Slots + 20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [63:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CfgStackBase) stk_base = val;
    else stk_len = {32'd0, val[31:0]};
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic void queue_req(logic [2:0] c, logic [63:0] a, logic [63:0] l);
    pending_reqs.push_back('{l, a, c});
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  initial begin
    logic [63:0] starts [8];
    logic [2:0] c;
    int pick;
    stk_base = 0; stk_len = 0; stk_off = 0;
    for (int i = 0; i < Slots; i++) begin
      blk_valid[i] = 0; blk_native[i] = 0; blk_freed[i] = 0;
      blk_start[i] = 0; blk_len[i] = 0;
    end
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part with stack base 0x1000 and stack size 0x100.
    write_reg(CfgStackBase, 64'h1000);
    write_reg(CfgStackSize, 64'h100);
    queue_req(CmdRecManaged, 64'd0, 64'd16);           // out of memory
    queue_req(CmdRecManaged, 64'h8000, 64'h40);
    queue_req(CmdRecNative, 64'h9000, 64'h20);
    queue_req(CmdRecNative, 64'h8000, 64'h10);         // replaces managed entry
    queue_req(CmdFree, 64'd0, 64'd0);
    queue_req(CmdFree, 64'h7777, 64'd0);               // not a block
    queue_req(CmdRecManaged, 64'hA000, 64'h10);
    queue_req(CmdFree, 64'hA000, 64'd0);               // managed
    queue_req(CmdFree, 64'h9000, 64'd0);
    queue_req(CmdFree, 64'h9000, 64'd0);               // double free
    queue_req(CmdValidate, 64'h9004, 64'd4);           // freed
    queue_req(CmdValidate, 64'h8008, 64'h10);          // overrun
    queue_req(CmdValidate, 64'h8010, 64'd4);           // past the end
    queue_req(CmdValidate, 64'd0, 64'd4);              // null
    queue_req(CmdValidate, 64'd0, 64'd0);
    queue_req(CmdValidate, '1, 64'd2);                 // wraps
    queue_req(CmdStkAlloc, 64'd0, 64'd5);
    queue_req(CmdStkAlloc, 64'd0, 64'd8);              // aligned up
    queue_req(CmdValidate, 64'h1000, 64'h10);
    queue_req(CmdValidate, 64'h1008, 64'h20);          // above pointer
    queue_req(CmdStkAlloc, 64'd0, '1);                 // overflow
    queue_req(CmdStkRestore, 64'h5, 64'd0);            // outside the region
    queue_req(CmdStkAlloc, 64'd0, 64'd1);
    queue_req(3'd6, '1, '1);
    queue_req(3'd7, 64'd1, 64'd1);
    drain_all();

    // Fill the table to check the full status.
    for (int i = 0; i < Slots + 2; i++)
      queue_req(CmdRecNative, 64'h100000 + 64'(i) * 64'h100, 64'h80);
    drain_all();

    // Random phases with various settings, including the extremes.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_reg(CfgStackBase, 64'd0); write_reg(CfgStackSize, 64'd0); end
        1: begin write_reg(CfgStackBase, '1); write_reg(CfgStackSize, 64'hFFFF_FFFF); end
        2: begin write_reg(CfgStackBase, 64'h2003); write_reg(CfgStackSize, 64'h400); end
        default: begin write_reg(CfgStackBase, rand64()); write_reg(CfgStackSize, rand64()); end
      endcase
      for (int k = 0; k < 8; k++)
        starts[k] = (k == 0) ? stk_base + 64'h1_0000 : rand64() & ~64'hFFF;
      for (int n = 0; n < 150; n++) begin
        c = 3'($urandom_range(0, 7));
        pick = $urandom_range(0, 7);
        case ($urandom_range(0, 9))
          0: queue_req(c, rand64(), rand64());
          1: queue_req(c, starts[pick] + 64'($urandom_range(0, 300)),
                       $urandom_range(0, 3) == 0 ? rand64() : 64'($urandom_range(0, 300)));
          2: queue_req(c, stk_base + 64'($urandom_range(0, 1100)),
                       64'($urandom_range(0, 64)));
          default: queue_req(c > 5 ? 3'(c - 3) : c, starts[pick] + ($urandom_range(0, 1) ?
                             64'd0 : 64'($urandom_range(0, 256))), 64'($urandom_range(0, 256)));
        endcase
      end
      drain_all();
    end

    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
